FILE: hdl/stable_descending_key_sort_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable descending key sort unit
// Shared wrappers so that every check uses the same clock and reset handling.
// ----------------------------------------------------------------------------
`ifndef STABLE_DESCENDING_KEY_SORT_UNIT_DEFINES_SVH
`define STABLE_DESCENDING_KEY_SORT_UNIT_DEFINES_SVH

// Check sampled on the rising edge of clk, switched off while rst is high.
`define SKSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check sampled on the rising edge of clk that also holds during reset.
`define SKSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/sksu_pkg.sv
// ----------------------------------------------------------------------------
// sksu_pkg
// Shared types and fixed field widths of the stable descending key sort unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sksu_pkg;

  // Fixed widths of the stream fields.
  localparam int FIELD_W     = 16;
  localparam int KEY_OUT_W   = 17;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // Key selection codes for the configuration register.
  localparam logic KEY_LONGEST = 1'b0;
  localparam logic KEY_SUM     = 1'b1;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic insert;  // a rectangle is being placed into the chain
    logic drain;   // the chain moves one place towards the output
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/stable_descending_key_sort_unit.sv
// ----------------------------------------------------------------------------
// stable_descending_key_sort_unit
// Sorts a set of rectangles by descending key, ties in arrival order.
// ----------------------------------------------------------------------------
// Rectangles arrive one transaction per clock while the unit is loading; each
// one is given a key (the longer side, or the sum of both sides, as the key
// mode register selects at the moment of arrival) and is placed at once into
// a chain of CAPACITY cells that is always kept in sorted order. Placement
// does not depend on the fill level, because the key is compared in
// every cell in parallel and each displaced cell takes its left neighbour's
// entry. The transaction carrying tlast closes the set: the chain then drains
// through cell 0 into the output register, one result per cycle while the
// downstream side is ready. The input is not ready during the drain. Rectangles
// that arrive when the chain is full are dropped and every result of that set
// has the overflow flag in tuser set; a final rectangle that is dropped still
// starts the drain. Only the low SIDE_BITS bits of each side are kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stable_descending_key_sort_unit_defines.svh"

module stable_descending_key_sort_unit
  import sksu_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int SIDE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: key mode, written whenever cfg_we is high.
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // rect_width, rect_height, rect_tag
  input  logic                   s_axis_tlast,   // is_final
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_tag, out_width, out_height,
                                                 // out_key, zero padding
  output logic                   m_axis_tlast,   // end_of_run
  output logic                   m_axis_tuser    // overflowed
);

  // Sides wider than the stream field cannot occur, so the stored width is
  // capped at the field width.
  localparam int SW     = (SIDE_BITS < FIELD_W) ? SIDE_BITS : FIELD_W;
  localparam int KEY_W  = SW + 1;
  localparam int DATA_W = 2 * SW + FIELD_W;
  localparam int CW     = $clog2(CAPACITY + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic          dropped;
  logic          key_mode;

  logic [SW-1:0]     in_w;
  logic [SW-1:0]     in_h;
  logic [KEY_W-1:0]  in_key;
  logic [DATA_W-1:0] in_data;

  logic in_acc;
  logic full;
  logic load_out;
  cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] moves;
  logic [KEY_W-1:0]    cell_key  [CAPACITY];
  logic [DATA_W-1:0]   cell_data [CAPACITY];

  logic [KEY_W-1:0]  out_key;
  logic [DATA_W-1:0] out_data;

  // Key mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= KEY_LONGEST;
    end else if (cfg_we) begin
      key_mode <= cfg_wdata;
    end
  end

  // Key of the arriving rectangle, computed with the mode now in force.
  assign in_w = s_axis_tdata[SW-1:0];
  assign in_h = s_axis_tdata[FIELD_W +: SW];

  always_comb begin
    if (key_mode == KEY_SUM) begin
      in_key = {1'b0, in_w} + {1'b0, in_h};
    end else begin
      in_key = (in_w > in_h) ? {1'b0, in_w} : {1'b0, in_h};
    end
  end

  assign in_data = {s_axis_tdata[2*FIELD_W +: FIELD_W], in_h, in_w};

  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (count == CW'(CAPACITY));
  assign load_out      = (state == ST_DRAIN) && (!m_axis_tvalid || m_axis_tready);

  assign ctrl.insert = in_acc && !full;
  assign ctrl.drain  = load_out;

  // Cells below the fill count hold live entries, in descending key order.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (CW'(i) < count);

      if (i == 0) begin : g_first
        sksu_cell #(.KEY_W(KEY_W), .DATA_W(DATA_W)) u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[i]),
          .new_key    (in_key),
          .new_data   (in_data),
          .prev_moves (1'b0),
          .prev_key   (in_key),
          .prev_data  (in_data),
          .next_key   (cell_key[i+1]),
          .next_data  (cell_data[i+1]),
          .moves      (moves[i]),
          .key        (cell_key[i]),
          .data       (cell_data[i])
        );
      end else if (i == CAPACITY - 1) begin : g_last
        sksu_cell #(.KEY_W(KEY_W), .DATA_W(DATA_W)) u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[i]),
          .new_key    (in_key),
          .new_data   (in_data),
          .prev_moves (moves[i-1]),
          .prev_key   (cell_key[i-1]),
          .prev_data  (cell_data[i-1]),
          .next_key   ({KEY_W{1'b0}}),
          .next_data  ({DATA_W{1'b0}}),
          .moves      (moves[i]),
          .key        (cell_key[i]),
          .data       (cell_data[i])
        );
      end else begin : g_mid
        sksu_cell #(.KEY_W(KEY_W), .DATA_W(DATA_W)) u_cell (
          .clk        (clk),
          .ctrl       (ctrl),
          .occupied   (occ[i]),
          .new_key    (in_key),
          .new_data   (in_data),
          .prev_moves (moves[i-1]),
          .prev_key   (cell_key[i-1]),
          .prev_data  (cell_data[i-1]),
          .next_key   (cell_key[i+1]),
          .next_data  (cell_data[i+1]),
          .moves      (moves[i]),
          .key        (cell_key[i]),
          .data       (cell_data[i])
        );
      end
    end
  endgenerate

  // Sequencer: fill count, overflow flag and load/drain state. The drain
  // always has at least one entry, since a final rectangle is either stored
  // or dropped into an already full chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else if (state == ST_LOAD) begin
      if (in_acc) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
        if (s_axis_tlast) begin
          state <= ST_DRAIN;
        end
      end
    end else if (load_out) begin
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        state   <= ST_LOAD;
        dropped <= 1'b0;
      end
    end
  end

  // Output register: cell 0 is taken out as the chain moves down.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_key      <= cell_key[0];
      out_data     <= cell_data[0];
      m_axis_tlast <= (count == CW'(1));
      m_axis_tuser <= dropped;
    end
  end

  assign m_axis_tdata = {
    {(OUT_TDATA_W - 3 * FIELD_W - KEY_OUT_W){1'b0}},
    KEY_OUT_W'(out_key),
    FIELD_W'(out_data[SW +: SW]),
    FIELD_W'(out_data[SW-1:0]),
    out_data[2*SW +: FIELD_W]
  };

  // The fill count never passes the chain length.
  `SKSU_ASSERT(a_count_bound, count <= CW'(CAPACITY),
               "fill count exceeds capacity")
  // A drain never starts or runs on an empty chain.
  `SKSU_ASSERT(a_drain_nonempty, (state == ST_DRAIN) |-> (count != '0),
               "drain with no stored entry")
  // The last entry taken out ends the run and empties the unit.
  `SKSU_ASSERT(a_run_end, (load_out && count == CW'(1)) |=>
               (m_axis_tlast && state == ST_LOAD && count == '0 && !dropped),
               "run did not close after its last entry")
  // The overflow flag only rises when a rectangle meets a full chain.
  `SKSU_ASSERT(a_drop_cause, $rose(dropped) |-> $past(in_acc && full),
               "overflow flag set without a dropped rectangle")

endmodule

`default_nettype wire

FILE: hdl/sksu_cell.sv
// ----------------------------------------------------------------------------
// sksu_cell
// One slot of the insertion chain: holds one entry and its key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sksu_cell
  import sksu_pkg::*;
#(
  parameter int KEY_W  = 17,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              occupied,
  input  logic [KEY_W-1:0]  new_key,
  input  logic [DATA_W-1:0] new_data,
  input  logic              prev_moves,
  input  logic [KEY_W-1:0]  prev_key,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [KEY_W-1:0]  next_key,
  input  logic [DATA_W-1:0] next_data,
  output logic              moves,
  output logic [KEY_W-1:0]  key,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_q;

  // A strictly greater key displaces this entry, so equal keys stay in
  // arrival order. An empty slot always gives way.
  assign moves = !occupied || (new_key > key);
  assign data  = data_q;

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      key    <= next_key;
      data_q <= next_data;
    end else if (ctrl.insert && moves) begin
      if (prev_moves) begin
        key    <= prev_key;
        data_q <= prev_data;
      end else begin
        key    <= new_key;
        data_q <= new_data;
      end
    end
  end

endmodule

`default_nettype wire
